[hdl/usbep0_pkg.sv]
// Types and constants shared by the endpoint-0 standard request engine.
// No dependencies; compiled first.
`default_nettype none

package usbep0_pkg;

  // Largest data packet on endpoint 0.
  localparam int unsigned Ep0Bytes = 64;

  // Descriptor length registers.
  localparam int unsigned NumCfg  = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 8;

  localparam logic [2:0] CfgDevice  = 3'd0;
  localparam logic [2:0] CfgConfig  = 3'd1;
  localparam logic [2:0] CfgLang    = 3'd2;

  // Reset lengths, register 0 in the low byte.
  localparam logic [NumCfg-1:0][CfgW-1:0] CfgReset = {
    8'd2, 8'd2, 8'd2, 8'd2, 8'd4, 8'd67, 8'd18
  };

  // Event kinds.
  typedef enum logic [1:0] {
    EvSetup    = 2'd0,
    EvInToken  = 2'd1,
    EvOutToken = 2'd2,
    EvBusReset = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    InNak   = 2'd0,
    InAck   = 2'd1,
    InStall = 2'd2,
    InKeep  = 2'd3
  } in_reply_e;

  typedef enum logic [1:0] {
    OutAck   = 2'd0,
    OutStall = 2'd1,
    OutKeep  = 2'd2
  } out_reply_e;

  typedef enum logic [1:0] {
    SrcNone   = 2'd0,
    SrcDescr  = 2'd1,
    SrcConfig = 2'd2,
    SrcStatus = 2'd3
  } src_e;

  // bmRequestType type field, bits 6:5.
  localparam logic [1:0] KindStd   = 2'd0;
  localparam logic [1:0] KindClass = 2'd1;

  // Standard request codes.
  localparam logic [7:0] RqGetStatus  = 8'h00;
  localparam logic [7:0] RqSetAddress = 8'h05;
  localparam logic [7:0] RqGetDescr   = 8'h06;
  localparam logic [7:0] RqGetConfig  = 8'h08;
  localparam logic [7:0] RqSetConfig  = 8'h09;
  localparam logic [7:0] RqNone       = 8'hff;

  // Descriptor types in the high byte of wValue.
  localparam logic [7:0] DtDevice = 8'd1;
  localparam logic [7:0] DtConfig = 8'd2;
  localparam logic [7:0] DtString = 8'd3;

  localparam logic [2:0] DescrDevice = 3'd0;
  localparam logic [2:0] DescrConfig = 3'd1;
  localparam logic [2:0] DescrLang   = 3'd2;
  // String indices above this one fall back to the serial string.
  localparam logic [7:0] MaxStrIdx   = 8'd4;
  localparam logic [2:0] SerialStr   = 3'd3;

  typedef struct packed {
    ev_e         req_type;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
    logic [15:0] length_requested;
  } req_t;

  typedef struct packed {
    in_reply_e  in_reply;
    logic       in_toggle;
    out_reply_e out_reply;
    logic       out_toggle;
    logic [6:0] tx_len;
    src_e       payload_source;
    logic [2:0] descr_index;
    logic [7:0] descr_offset;
    logic       load_address;
    logic [6:0] device_address;
    logic [7:0] config_value;
    logic       class_pass;
  } rsp_t;

endpackage

`default_nettype wire

[hdl/usbep0_if.sv]
// Valid/ready channel interfaces for endpoint-0 events and their results.
// Stand-alone; field widths follow usbep0_pkg.
`default_nettype none

interface usbep0_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [7:0]  value_low;
  logic [7:0]  value_high;
  logic [15:0] length_requested;

  modport source (
    output valid, req_type, request_type, request_code, value_low, value_high,
           length_requested,
    input  ready
  );
  modport sink (
    input  valid, req_type, request_type, request_code, value_low, value_high,
           length_requested,
    output ready
  );
endinterface

interface usbep0_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] in_reply;
  logic       in_toggle;
  logic [1:0] out_reply;
  logic       out_toggle;
  logic [6:0] tx_len;
  logic [1:0] payload_source;
  logic [2:0] descr_index;
  logic [7:0] descr_offset;
  logic       load_address;
  logic [6:0] device_address;
  logic [7:0] config_value;
  logic       class_pass;

  modport source (
    output valid, in_reply, in_toggle, out_reply, out_toggle, tx_len, payload_source,
           descr_index, descr_offset, load_address, device_address, config_value,
           class_pass,
    input  ready
  );
  modport sink (
    input  valid, in_reply, in_toggle, out_reply, out_toggle, tx_len, payload_source,
           descr_index, descr_offset, load_address, device_address, config_value,
           class_pass,
    output ready
  );
endinterface

`default_nettype wire

[hdl/usb_ep0_standard_request_engine_unit.sv]
// Endpoint-0 standard request engine: decodes SETUP/IN/OUT/bus reset events.
// Depends on usbep0_pkg and the channel interfaces in usbep0_if.sv.
// Channel  | Dir | Handshake    | Carries
// req_i    | in  | valid/ready  | one endpoint-0 event
// rsp_o    | out | valid/ready  | handshakes, toggles, chunk and address info
// cfg_*_i  | in  | write enable | descriptor length registers, index 0..6
//
// Each event passes through an input register, then the decode and clamp
// logic, which updates the request state and fills the result register.
// One event is accepted every cycle while results are taken.
// A stalled result holds the result register; the input register still takes
// one more event. Reset clears the state and loads the default lengths.
`default_nettype none

module usb_ep0_standard_request_engine_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  usbep0_req_if.sink                        req_i,
  usbep0_rsp_if.source                      rsp_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [usbep0_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [usbep0_pkg::CfgW-1:0]    cfg_data_i
);
  import usbep0_pkg::*;

  localparam logic [15:0] Ep0Len = 16'(Ep0Bytes);

  logic [CfgW-1:0] cfg_q [NumCfg];

  logic s1_valid_q;
  req_t s1_q;
  logic rsp_valid_q;
  rsp_t rsp_q;
  rsp_t rsp_d;
  logic s1_adv;
  logic req_acc;

  logic [7:0]  pend_req_q, pend_req_d;
  logic [1:0]  pend_kind_q, pend_kind_d;
  logic [15:0] rem_q, rem_d;
  logic [2:0]  cur_descr_q, cur_descr_d;
  logic [7:0]  cur_off_q, cur_off_d;
  logic [6:0]  addr_q, addr_d;
  logic [7:0]  conf_q, conf_d;
  logic        tog_q, tog_d;

  // Descriptor selection and clamps for a setup packet.
  logic [2:0]  str_sel;
  logic [2:0]  dsel;
  logic [7:0]  dlen;
  logic        dvalid;
  logic [15:0] setup_rem;
  logic [15:0] setup_chunk;
  logic [15:0] in_chunk;

  assign s1_adv    = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || !rsp_valid_q || rsp_o.ready;
  assign req_acc   = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfg; i++) begin
        cfg_q[i] <= CfgReset[i];
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumCfg))) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_q.req_type         <= ev_e'(req_i.req_type);
      s1_q.request_type     <= req_i.request_type;
      s1_q.request_code     <= req_i.request_code;
      s1_q.value_low        <= req_i.value_low;
      s1_q.value_high       <= req_i.value_high;
      s1_q.length_requested <= req_i.length_requested;
    end
  end

  always_comb begin
    str_sel = (s1_q.value_low <= MaxStrIdx) ? s1_q.value_low[2:0] : SerialStr;
    dvalid  = 1'b1;
    dsel    = DescrDevice;
    dlen    = cfg_q[CfgDevice];
    case (s1_q.value_high)
      DtDevice: begin
        dsel = DescrDevice;
        dlen = cfg_q[CfgDevice];
      end
      DtConfig: begin
        dsel = DescrConfig;
        dlen = cfg_q[CfgConfig];
      end
      DtString: begin
        dsel = DescrLang + str_sel;
        dlen = cfg_q[CfgLang + str_sel];
      end
      default: dvalid = 1'b0;
    endcase
    setup_rem   = (s1_q.length_requested > {8'd0, dlen}) ? {8'd0, dlen}
                                                         : s1_q.length_requested;
    setup_chunk = (setup_rem >= Ep0Len) ? Ep0Len : setup_rem;
    in_chunk    = (rem_q >= Ep0Len) ? Ep0Len : rem_q;
  end

  always_comb begin
    logic        stall;
    logic        cls;
    logic [15:0] len;
    stall       = 1'b0;
    cls         = 1'b0;
    len         = '0;
    pend_req_d  = pend_req_q;
    pend_kind_d = pend_kind_q;
    rem_d       = rem_q;
    cur_descr_d = cur_descr_q;
    cur_off_d   = cur_off_q;
    addr_d      = addr_q;
    conf_d      = conf_q;
    tog_d       = tog_q;

    rsp_d                = '0;
    rsp_d.in_reply       = InKeep;
    rsp_d.out_reply      = OutKeep;
    rsp_d.payload_source = SrcNone;

    unique case (s1_q.req_type)
      EvSetup: begin
        rem_d       = s1_q.length_requested;
        pend_req_d  = s1_q.request_code;
        pend_kind_d = s1_q.request_type[6:5];
        if (s1_q.request_type[6:5] == KindStd) begin
          case (s1_q.request_code)
            RqGetDescr: begin
              if (dvalid) begin
                cur_descr_d          = dsel;
                rem_d                = setup_rem;
                len                  = setup_chunk;
                cur_off_d            = setup_chunk[7:0];
                rsp_d.payload_source = SrcDescr;
                rsp_d.descr_index    = dsel;
              end else begin
                stall = 1'b1;
              end
            end
            RqSetAddress: addr_d = s1_q.value_low[6:0];
            RqGetConfig: begin
              rem_d = (s1_q.length_requested > 16'd1) ? 16'd1 : s1_q.length_requested;
              len   = rem_d;
              rsp_d.payload_source = SrcConfig;
            end
            RqSetConfig: conf_d = s1_q.value_low;
            RqGetStatus: begin
              rem_d = (s1_q.length_requested > 16'd2) ? 16'd2 : s1_q.length_requested;
              len   = rem_d;
              rsp_d.payload_source = SrcStatus;
            end
            default: stall = 1'b1;
          endcase
        end else if (s1_q.request_type[6:5] == KindClass) begin
          cls = 1'b1;
        end else begin
          stall = 1'b1;
        end

        if (cls) begin
          // Handshakes stay with the class logic.
        end else if (stall) begin
          pend_req_d           = RqNone;
          rsp_d.payload_source = SrcNone;
          rsp_d.descr_index    = '0;
          tog_d                = 1'b1;
          rsp_d.in_reply       = InStall;
          rsp_d.out_reply      = OutStall;
          rsp_d.out_toggle     = 1'b1;
        end else begin
          rem_d            = rem_d - len;
          rsp_d.tx_len     = len[6:0];
          tog_d            = 1'b1;
          rsp_d.in_reply   = InAck;
          rsp_d.out_reply  = OutAck;
          rsp_d.out_toggle = 1'b1;
        end
      end
      EvInToken: begin
        if (pend_kind_q == KindClass) begin
          cls = 1'b1;
        end else if (pend_req_q == RqGetDescr) begin
          rsp_d.payload_source = SrcDescr;
          rsp_d.descr_index    = cur_descr_q;
          rsp_d.descr_offset   = cur_off_q;
          cur_off_d            = cur_off_q + in_chunk[7:0];
          rem_d                = rem_q - in_chunk;
          rsp_d.tx_len         = in_chunk[6:0];
          tog_d                = !tog_q;
        end else begin
          // Status stage for every request but a descriptor read; the address lands here.
          rsp_d.load_address = (pend_req_q == RqSetAddress);
          tog_d              = 1'b0;
          rsp_d.in_reply     = InNak;
          rsp_d.out_reply    = OutAck;
          rsp_d.out_toggle   = 1'b1;
        end
      end
      EvOutToken: begin
        if (pend_kind_q == KindClass) begin
          cls = 1'b1;
        end else begin
          tog_d           = 1'b1;
          rsp_d.in_reply  = InAck;
          rsp_d.out_reply = OutAck;
        end
      end
      EvBusReset: begin
        conf_d          = '0;
        addr_d          = '0;
        tog_d           = 1'b0;
        rsp_d.in_reply  = InNak;
        rsp_d.out_reply = OutAck;
      end
      default: ;
    endcase

    rsp_d.in_toggle      = tog_d;
    rsp_d.device_address = addr_d;
    rsp_d.config_value   = conf_d;
    rsp_d.class_pass     = cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_req_q  <= '0;
      pend_kind_q <= '0;
      rem_q       <= '0;
      cur_descr_q <= '0;
      cur_off_q   <= '0;
      addr_q      <= '0;
      conf_q      <= '0;
      tog_q       <= 1'b0;
    end else if (s1_adv) begin
      pend_req_q  <= pend_req_d;
      pend_kind_q <= pend_kind_d;
      rem_q       <= rem_d;
      cur_descr_q <= cur_descr_d;
      cur_off_q   <= cur_off_d;
      addr_q      <= addr_d;
      conf_q      <= conf_d;
      tog_q       <= tog_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.in_reply       = rsp_q.in_reply;
  assign rsp_o.in_toggle      = rsp_q.in_toggle;
  assign rsp_o.out_reply      = rsp_q.out_reply;
  assign rsp_o.out_toggle     = rsp_q.out_toggle;
  assign rsp_o.tx_len         = rsp_q.tx_len;
  assign rsp_o.payload_source = rsp_q.payload_source;
  assign rsp_o.descr_index    = rsp_q.descr_index;
  assign rsp_o.descr_offset   = rsp_q.descr_offset;
  assign rsp_o.load_address   = rsp_q.load_address;
  assign rsp_o.device_address = rsp_q.device_address;
  assign rsp_o.config_value   = rsp_q.config_value;
  assign rsp_o.class_pass     = rsp_q.class_pass;

  // A held event in the input register must not be lost while output stalls.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("input register dropped an event");

  // A stall always arms both directions with toggle one.
  a_stall_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.in_reply == InStall |->
      rsp_q.out_reply == OutStall && rsp_q.in_toggle && rsp_q.tx_len == 7'd0)
    else $error("inconsistent stall result");

  // No chunk exceeds the endpoint size.
  a_chunk_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> rsp_q.tx_len <= 7'(Ep0Bytes))
    else $error("chunk larger than endpoint size");

  // Descriptor fields are only reported with descriptor payloads.
  a_descr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.payload_source != SrcDescr |->
      rsp_q.descr_index == 3'd0 && rsp_q.descr_offset == 8'd0)
    else $error("descriptor fields set without descriptor payload");

  // The address is applied only in a status stage answered with NAK on IN.
  a_load_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.load_address |->
      rsp_q.in_reply == InNak && !rsp_q.class_pass)
    else $error("address load outside status stage");

endmodule

`default_nettype wire
